// File: design/nvhq_pkg.sv
package nvhq_pkg;

  // Entries per submission and completion queue.
  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int SLOT_W    = 3;
  localparam int CID_W     = 16;
  localparam int STATUS_W  = 16;
  localparam int RESULT_W  = 32;
  localparam int STRIDE_W  = 4;
  localparam int POLL_W    = 27;
  localparam int OFFSET_W  = 19;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 27;

  localparam logic [OFFSET_W-1:0] DOORBELL_BASE    = 19'h01000;
  localparam logic [POLL_W-1:0]   POLL_LIMIT_RESET = 27'd100000000;

  typedef logic [PTR_W-1:0] ptr_t;
  localparam ptr_t PTR_LAST = ptr_t'(QUEUE_DEPTH - 1);

  // Operation codes on the input channel.
  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_POLL   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_EXP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT = 2'd1;

  typedef enum logic [2:0] {
    OUT_PENDING     = 3'd0,
    OUT_OK          = 3'd1,
    OUT_ERROR       = 3'd2,
    OUT_ID_MISMATCH = 3'd3,
    OUT_TIMEOUT     = 3'd4
  } outcome_t;

  typedef struct packed {
    logic                op;
    logic                qsel;
    logic [STATUS_W-1:0] status;
    logic [CID_W-1:0]    cid;
    logic [RESULT_W-1:0] result;
  } item_t;

  // Queue controller decisions for one transaction.
  typedef struct packed {
    logic                db_write;
    logic                db_head;   // 1 for a completion head doorbell
    logic                qsel;
    logic [SLOT_W-1:0]   db_value;
    logic [SLOT_W-1:0]   slot;
    logic [CID_W-1:0]    cmd_id;
    outcome_t            outcome;
    logic [RESULT_W-1:0] cpl_result;
  } qresult_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_LAST) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic logic [SLOT_W-1:0] ptr_to_field(input ptr_t p);
    logic [PTR_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, p};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

// File: design/nvhq_queue_ctrl.sv
module nvhq_queue_ctrl import nvhq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              update,
  input  item_t             item,
  input  logic [POLL_W-1:0] poll_limit,
  output qresult_t          res
);

  ptr_t              sq_tail_r   [2];
  ptr_t              cq_head_r   [2];
  logic              phase_r     [2];
  logic [CID_W-1:0]  last_cid_r  [2];
  logic [POLL_W-1:0] poll_cnt_r  [2];

  ptr_t              sq_tail_nxt;
  ptr_t              cq_head_nxt;
  logic              phase_nxt;
  logic [CID_W-1:0]  last_cid_nxt;
  logic [POLL_W-1:0] poll_cnt_nxt;

  logic              q;
  logic [POLL_W-1:0] cnt_inc;
  logic [14:0]       status_code;

  assign q           = item.qsel;
  assign cnt_inc     = poll_cnt_r[q] + 1'b1;
  assign status_code = item.status[STATUS_W-1:1];

  always_comb begin
    sq_tail_nxt  = sq_tail_r[q];
    cq_head_nxt  = cq_head_r[q];
    phase_nxt    = phase_r[q];
    last_cid_nxt = last_cid_r[q];
    poll_cnt_nxt = poll_cnt_r[q];

    res            = '0;
    res.qsel       = q;
    res.outcome    = OUT_PENDING;
    res.cmd_id     = last_cid_r[q];
    res.slot       = ptr_to_field(cq_head_r[q]);

    if (item.op == OP_SUBMIT) begin
      last_cid_nxt = last_cid_r[q] + 1'b1;
      sq_tail_nxt  = ptr_inc(sq_tail_r[q]);
      poll_cnt_nxt = '0;
      res.slot     = ptr_to_field(sq_tail_r[q]);
      res.cmd_id   = last_cid_nxt;
      res.db_write = 1'b1;
      res.db_value = ptr_to_field(sq_tail_nxt);
    end else if (item.status[0] != phase_r[q]) begin
      // Entry not yet posted by the controller.
      if (cnt_inc >= poll_limit) begin
        res.outcome  = OUT_TIMEOUT;
        poll_cnt_nxt = '0;
      end else begin
        poll_cnt_nxt = cnt_inc;
      end
    end else begin
      cq_head_nxt    = ptr_inc(cq_head_r[q]);
      phase_nxt      = (cq_head_nxt == '0) ? ~phase_r[q] : phase_r[q];
      poll_cnt_nxt   = '0;
      res.db_write   = 1'b1;
      res.db_head    = 1'b1;
      res.db_value   = ptr_to_field(cq_head_nxt);
      res.cpl_result = item.result;
      if (status_code != '0) begin
        res.outcome = OUT_ERROR;
      end else if (last_cid_r[q] != '0 && item.cid != last_cid_r[q]) begin
        res.outcome = OUT_ID_MISMATCH;
      end else begin
        res.outcome = OUT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        sq_tail_r[i]  <= '0;
        cq_head_r[i]  <= '0;
        phase_r[i]    <= 1'b1;
        last_cid_r[i] <= '0;
        poll_cnt_r[i] <= '0;
      end
    end else if (update) begin
      sq_tail_r[q]  <= sq_tail_nxt;
      cq_head_r[q]  <= cq_head_nxt;
      phase_r[q]    <= phase_nxt;
      last_cid_r[q] <= last_cid_nxt;
      poll_cnt_r[q] <= poll_cnt_nxt;
    end
  end

endmodule

// File: design/nvhq_doorbell_addr.sv
module nvhq_doorbell_addr import nvhq_pkg::*; (
  input  logic                db_write,
  input  logic                qsel,
  input  logic                db_head,
  input  logic [STRIDE_W-1:0] stride_exp,
  output logic [OFFSET_W-1:0] offset
);

  // Offset is base + (2*q + head) * (4 << stride_exp).
  logic [4:0] shamt;
  logic [1:0] reg_num;

  assign shamt   = {1'b0, stride_exp} + 5'd2;
  assign reg_num = {qsel, db_head};
  assign offset  = db_write ? (DOORBELL_BASE + (OFFSET_W'(reg_num) << shamt)) : '0;

endmodule

// File: design/nvme_host_queue_pair_engine.sv
// Host-side doorbell engine for an admin queue pair (queue 0) and one I/O
// queue pair (queue 1).
//
// Input channel (in_valid / in_stall): each transaction is either a submit,
// which hands out the next command id and submission slot and rings the
// tail doorbell, or a poll of the completion entry at the head, which
// either consumes it and rings the head doorbell or counts toward a timeout.
// Output channel (out_valid / out_stall): exactly one result transaction per
// input transaction, in order.
// Configuration port (cfg_valid / cfg_ready): index 0 sets the doorbell
// stride exponent, index 1 the poll timeout limit. It is always ready and
// should only be written while no transaction is in flight.
//
// Each accepted transaction goes through one input register, then the
// queue update and doorbell address logic feeding the result register. One
// transaction is accepted every cycle while in_stall is low. When the
// receiver stalls, the result register holds and the input register keeps
// the next transaction, so in_stall rises only when both are full.
// Reset clears all queue pointers, ids and counters, sets the expected phase
// of both queues to one and restores the configuration reset values at once.
module nvme_host_queue_pair_engine import nvhq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic                 in_queue_select,
  input  logic [STATUS_W-1:0]  in_entry_status,
  input  logic [CID_W-1:0]     in_entry_cid,
  input  logic [RESULT_W-1:0]  in_entry_result,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_doorbell_write,
  output logic [OFFSET_W-1:0]  out_doorbell_offset,
  output logic [SLOT_W-1:0]    out_doorbell_value,
  output logic [SLOT_W-1:0]    out_slot_index,
  output logic [CID_W-1:0]     out_command_id,
  output logic [2:0]           out_outcome,
  output logic [RESULT_W-1:0]  out_completion_result,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic [STRIDE_W-1:0] stride_exp_r;
  logic [POLL_W-1:0]   poll_limit_r;

  logic                stage_valid_r;
  item_t               stage_item_r;
  logic                out_valid_r;
  qresult_t            out_res_r;
  logic [OFFSET_W-1:0] out_offset_r;

  qresult_t            qres;
  logic [OFFSET_W-1:0] db_offset;
  logic                advance;
  logic                in_take;

  // The staged transaction moves on when the result register is free or
  // being emptied in this cycle.
  assign advance   = stage_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = stage_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_exp_r <= '0;
      poll_limit_r <= POLL_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STRIDE_EXP: stride_exp_r <= cfg_data[STRIDE_W-1:0];
        CFG_POLL_LIMIT: poll_limit_r <= cfg_data[POLL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (!in_stall) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_item_r.op     <= in_operation;
      stage_item_r.qsel   <= in_queue_select;
      stage_item_r.status <= in_entry_status;
      stage_item_r.cid    <= in_entry_cid;
      stage_item_r.result <= in_entry_result;
    end
  end

  nvhq_queue_ctrl u_queue_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .update     (advance),
    .item       (stage_item_r),
    .poll_limit (poll_limit_r),
    .res        (qres)
  );

  nvhq_doorbell_addr u_doorbell_addr (
    .db_write   (qres.db_write),
    .qsel       (qres.qsel),
    .db_head    (qres.db_head),
    .stride_exp (stride_exp_r),
    .offset     (db_offset)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r    <= qres;
      out_offset_r <= db_offset;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_doorbell_write    = out_res_r.db_write;
  assign out_doorbell_offset   = out_offset_r;
  assign out_doorbell_value    = out_res_r.db_value;
  assign out_slot_index        = out_res_r.slot;
  assign out_command_id        = out_res_r.cmd_id;
  assign out_outcome           = out_res_r.outcome;
  assign out_completion_result = out_res_r.cpl_result;

  // The input side only backs up when a transaction is already staged.
  a_stall_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stage_valid_r)
    else $error("input stalled with an empty input register");

  // A result without a doorbell carries a zero address and value.
  a_no_doorbell_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_doorbell_write) |->
      (out_doorbell_offset == '0 && out_doorbell_value == '0))
    else $error("doorbell fields set without a doorbell write");

  // Every consumed completion rings the head doorbell; this checks its doorbell write.
  a_consumed_rings: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_outcome == OUT_OK || out_outcome == OUT_ERROR ||
                   out_outcome == OUT_ID_MISMATCH)) |-> out_doorbell_write)
    else $error("consumed completion without a doorbell write");

  // A timeout never consumes the entry.
  a_timeout_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome == OUT_TIMEOUT) |->
      (!out_doorbell_write && out_completion_result == '0))
    else $error("timeout reported together with a consumed entry");

  // A staged transaction that advances is in the result register in the next cycle.
  a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("advanced transaction missing from result register");

endmodule
